/* hdl/shs_pkg.sv */
`default_nettype none

package shs_pkg;

    localparam int WORD_W                = 32;
    localparam int COUNT_W               = 61;
    localparam int LENGTH_FIELD_BITS_DEF = 64;
    localparam logic [7:0] PAD_MARK      = 8'h80;

    // Round constants
    localparam logic [31:0] SHS_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // Initial chaining value
    localparam logic [31:0] SHS_H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // Source of the byte written into the block buffer
    typedef enum logic [1:0] {
        SRC_INPUT,
        SRC_MARK,
        SRC_ZERO,
        SRC_LEN
    } shs_src_t;

    typedef struct packed {
        logic     load_byte;
        shs_src_t byte_src;
        logic     len_capture;
        logic     init_work;
        logic     do_round;
        logic     update_hash;
        logic     out_advance;
        logic     clear_msg;
    } shs_cmd_t;

    typedef struct packed {
        logic pos_end;     // block position is 63
        logic pos_len;     // block position is 56
        logic round_last;  // round 63 in progress
        logic out_last;    // digest word 7 on the output
    } shs_status_t;

endpackage

`default_nettype wire

/* hdl/shs_ctrl.sv */
`default_nettype none

module shs_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 byte_valid,
    input  logic                 last_byte,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  shs_pkg::shs_status_t status,
    output shs_pkg::shs_cmd_t    cmd
);
    import shs_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MARK,
        ST_ZERO,
        ST_LEN,
        ST_INIT,
        ST_ROUND,
        ST_UPDATE,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        RET_IDLE,
        RET_MARK,
        RET_ZERO,
        RET_OUT
    } ret_t;

    state_t state_reg, state_next;
    ret_t   ret_reg, ret_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        cmd        = '0;
        cmd.byte_src = SRC_INPUT;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (byte_valid)
                    begin
                        cmd.load_byte = 1'b1;
                        cmd.byte_src  = SRC_INPUT;
                        if (status.pos_end)
                        begin
                            state_next = ST_INIT;
                            ret_next   = last_byte ? RET_MARK : RET_IDLE;
                        end
                        else if (last_byte)
                        begin
                            state_next = ST_MARK;
                        end
                    end
                    else if (last_byte)
                    begin
                        state_next = ST_MARK;
                    end
                end
            end
            ST_MARK:
            begin
                cmd.load_byte   = 1'b1;
                cmd.byte_src    = SRC_MARK;
                cmd.len_capture = 1'b1;
                if (status.pos_end)
                begin
                    state_next = ST_INIT;
                    ret_next   = RET_ZERO;
                end
                else
                begin
                    state_next = ST_ZERO;
                end
            end
            ST_ZERO:
            begin
                if (status.pos_len)
                begin
                    state_next = ST_LEN;
                end
                else
                begin
                    cmd.load_byte = 1'b1;
                    cmd.byte_src  = SRC_ZERO;
                    if (status.pos_end)
                    begin
                        state_next = ST_INIT;
                        ret_next   = RET_ZERO;
                    end
                end
            end
            ST_LEN:
            begin
                cmd.load_byte = 1'b1;
                cmd.byte_src  = SRC_LEN;
                if (status.pos_end)
                begin
                    state_next = ST_INIT;
                    ret_next   = RET_OUT;
                end
            end
            ST_INIT:
            begin
                cmd.init_work = 1'b1;
                state_next    = ST_ROUND;
            end
            ST_ROUND:
            begin
                cmd.do_round = 1'b1;
                if (status.round_last)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                cmd.update_hash = 1'b1;
                unique case (ret_reg)
                    RET_IDLE: state_next = ST_IDLE;
                    RET_MARK: state_next = ST_MARK;
                    RET_ZERO: state_next = ST_ZERO;
                    RET_OUT:  state_next = ST_OUT;
                    default:  state_next = ST_IDLE;
                endcase
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    if (status.out_last)
                    begin
                        cmd.clear_msg = 1'b1;
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        cmd.out_advance = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ret_reg   <= RET_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/shs_datapath.sv */
`default_nettype none

module shs_datapath #(
    parameter int LENGTH_FIELD_BITS = shs_pkg::LENGTH_FIELD_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [7:0]           data_byte,
    input  shs_pkg::shs_cmd_t    cmd,
    output shs_pkg::shs_status_t status,
    output logic [31:0]          digest_word,
    output logic [2:0]           word_index,
    output logic                 last_word
);
    import shs_pkg::*;

    function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
        return (v >> n) | (v << (32 - n));
    endfunction

    // Control registers
    logic [5:0]                   pos_reg, pos_next;
    logic [COUNT_W-1:0]           count_reg, count_next;
    logic [5:0]                   rnd_reg, rnd_next;
    logic [2:0]                   out_idx_reg, out_idx_next;
    logic [WORD_W-1:0]            h_reg [8];
    logic [WORD_W-1:0]            h_next [8];

    // Payload registers
    logic [23:0]                  acc_reg, acc_next;
    logic [WORD_W-1:0]            w_reg [16];
    logic [WORD_W-1:0]            w_next [16];
    logic [WORD_W-1:0]            v_reg [8];
    logic [WORD_W-1:0]            v_next [8];
    logic [LENGTH_FIELD_BITS-1:0] len_reg, len_next;

    logic [7:0]        byte_in;
    logic [63:0]       len_shift;
    logic [WORD_W-1:0] w_sched;
    logic [WORD_W-1:0] s0, s1, ch, mj, t1, t2;

    assign status.pos_end    = (pos_reg == 6'd63);
    assign status.pos_len    = (pos_reg == 6'd56);
    assign status.round_last = (rnd_reg == 6'd63);
    assign status.out_last   = (out_idx_reg == 3'd7);

    assign digest_word = h_reg[out_idx_reg];
    assign word_index  = out_idx_reg;
    assign last_word   = (out_idx_reg == 3'd7);

    // Length bytes leave most significant first, indexed by the block position
    assign len_shift = 64'(len_reg) << {pos_reg[2:0], 3'b000};

    always_comb
    begin
        case (cmd.byte_src)
            SRC_INPUT: byte_in = data_byte;
            SRC_MARK:  byte_in = PAD_MARK;
            SRC_ZERO:  byte_in = 8'h00;
            SRC_LEN:   byte_in = len_shift[63:56];
            default:   byte_in = 8'h00;
        endcase
    end

    // Round logic
    always_comb
    begin
        w_sched = (rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10))
                + w_reg[9]
                + (rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3))
                + w_reg[0];
        s1 = rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25);
        ch = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1 = v_reg[7] + s1 + ch + SHS_K[rnd_reg] + w_reg[0];
        s0 = rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22);
        mj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t2 = s0 + mj;
    end

    always_comb
    begin
        pos_next     = pos_reg;
        count_next   = count_reg;
        rnd_next     = rnd_reg;
        out_idx_next = out_idx_reg;
        acc_next     = acc_reg;
        len_next     = len_reg;
        h_next       = h_reg;
        w_next       = w_reg;
        v_next       = v_reg;

        if (cmd.load_byte)
        begin
            pos_next = pos_reg + 6'd1;
            acc_next = {acc_reg[15:0], byte_in};
            if (cmd.byte_src == SRC_INPUT)
            begin
                count_next = count_reg + COUNT_W'(1);
            end
            // Shift a completed word into the block buffer
            if (pos_reg[1:0] == 2'd3)
            begin
                for (int i = 0; i < 15; i++)
                begin
                    w_next[i] = w_reg[i+1];
                end
                w_next[15] = {acc_reg, byte_in};
            end
        end

        if (cmd.len_capture)
        begin
            len_next = LENGTH_FIELD_BITS'({count_reg, 3'b000});
        end

        if (cmd.init_work)
        begin
            v_next   = h_reg;
            rnd_next = 6'd0;
        end

        if (cmd.do_round)
        begin
            rnd_next = rnd_reg + 6'd1;
            for (int i = 0; i < 15; i++)
            begin
                w_next[i] = w_reg[i+1];
            end
            w_next[15] = w_sched;
            v_next[7] = v_reg[6];
            v_next[6] = v_reg[5];
            v_next[5] = v_reg[4];
            v_next[4] = v_reg[3] + t1;
            v_next[3] = v_reg[2];
            v_next[2] = v_reg[1];
            v_next[1] = v_reg[0];
            v_next[0] = t1 + t2;
        end

        if (cmd.update_hash)
        begin
            for (int i = 0; i < 8; i++)
            begin
                h_next[i] = h_reg[i] + v_reg[i];
            end
        end

        if (cmd.out_advance)
        begin
            out_idx_next = out_idx_reg + 3'd1;
        end

        if (cmd.clear_msg)
        begin
            h_next       = SHS_H_INIT;
            count_next   = '0;
            pos_next     = '0;
            out_idx_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            count_reg   <= '0;
            rnd_reg     <= '0;
            out_idx_reg <= '0;
            h_reg       <= SHS_H_INIT;
        end
        else
        begin
            pos_reg     <= pos_next;
            count_reg   <= count_next;
            rnd_reg     <= rnd_next;
            out_idx_reg <= out_idx_next;
            h_reg       <= h_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        len_reg <= len_next;
        w_reg   <= w_next;
        v_reg   <= v_next;
    end

endmodule

`default_nettype wire

/* hdl/sha256_byte_stream_hasher.sv */
`default_nettype none

// Channel   Handshake             Payload                               Dir
// input     in_valid / in_ready   data_byte, byte_valid, last_byte      in
// output    out_valid / out_ready digest_word, word_index, last_word    out
//
// The input takes one byte per cycle while in_ready is high; the 64th byte of a block
// starts a compression (load working variables, 64 rounds, chaining update).
// The closing request pads with the mark, zero bytes and the length, plus one or two
// compressions, then emits the 8 digest words, one per cycle while out_ready is high.
// The input stalls for each compression and from the closing request until the digest
// drains; reset clears the byte count and block position and reloads the chaining IV.

module sha256_byte_stream_hasher #(
    parameter int LENGTH_FIELD_BITS = shs_pkg::LENGTH_FIELD_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        byte_valid,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);
    import shs_pkg::*;

    shs_cmd_t    cmd;
    shs_status_t status;

    // Sequence byte loads, padding, rounds and digest readout
    shs_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .byte_valid (byte_valid),
        .last_byte  (last_byte),
        .in_ready   (in_ready),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .cmd        (cmd)
    );

    // Hold the block buffer, working variables and chaining value
    shs_datapath #(
        .LENGTH_FIELD_BITS (LENGTH_FIELD_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .data_byte   (data_byte),
        .cmd         (cmd),
        .status      (status),
        .digest_word (digest_word),
        .word_index  (word_index),
        .last_word   (last_word)
    );

    // Never take a request while the digest is on the output
    assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input ready while digest is pending");

    // The final digest word returns the block to accepting requests
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last_word) |=> (in_ready && !out_valid))
        else $error("block did not return to idle after digest");

    // Digest words advance by one per accepted word
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !last_word) |=>
            (out_valid && (word_index == $past(word_index) + 3'd1)))
        else $error("digest word index did not advance");

    // A taken closing request always stops the input at once
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && last_byte) |=> !in_ready)
        else $error("input accepted right after closing request");

endmodule

`default_nettype wire

/* dv/sha256_byte_stream_hasher_test.sv */
module sha256_byte_stream_hasher_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          RAND_REQS   = 140;   // random requests that carry or close a message
    localparam int          CALM_TAIL   = 30;    // no idling once this few requests remain
    localparam int          DRAIN_WAIT  = 300;   // padding plus two compressions, with margin
    localparam int          CYCLE_LIMIT = 400000;
    localparam logic [7:0]  MARK_BYTE   = 8'h80;
    localparam logic [5:0]  LEN_SLOT    = 6'd56; // padding from here on needs an extra block
    localparam int          BLOCK_EDGE_LENS [6] = '{55, 56, 57, 63, 64, 65};

    localparam logic [31:0] HASH_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // One input request: a message byte, an idle slot, or a message close.
    typedef struct {
        logic [7:0] data;
        logic       valid;
        logic       last;
    } hash_req_t;

    // One expected digest word as it should leave the output channel.
    typedef struct {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_entry_t;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte  = 8'h00;
    logic        byte_valid = 1'b0;
    logic        last_byte  = 1'b0;
    logic        out_valid;
    logic        out_ready  = 1'b0;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    hash_req_t     req_q [$];     // requests not yet offered to the block
    digest_entry_t digest_q [$];  // digest words predicted but not yet seen
    hash_req_t     cur_req;       // request currently held on the input port
    int            send_gap  = 0;
    int            hold_gap  = 0;
    int            fails     = 0;
    int            cycles    = 0;
    bit            calm      = 1'b0;

    // Running hash state of the predictor
    logic [31:0] chain_h [8];
    logic [31:0] blk_w [16];
    logic [60:0] msg_bytes;

    sha256_byte_stream_hasher dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_byte   (data_byte),
        .byte_valid  (byte_valid),
        .last_byte   (last_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .digest_word (digest_word),
        .word_index  (word_index),
        .last_word   (last_word)
    );

    always #5 clk = ~clk;

    // Abort on a hang; a correct run ends far below this.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $realtime, cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
        return (v >> n) | (v << (32 - n));
    endfunction

    // Start a fresh message: initial chaining value, zero length.
    task automatic restart_message();
        for (int j = 0; j < 8; j++)
            chain_h[j] = HASH_IV[j];
        for (int j = 0; j < 16; j++)
            blk_w[j] = '0;
        msg_bytes = '0;
    endtask

    // Place a byte big-endian at the current block position.
    task automatic pack_byte(input logic [5:0] pos, input logic [7:0] b);
        logic [4:0] sh;
        sh = 5'((3 - pos[1:0]) * 8);
        if (pos[1:0] == 2'd0)
            blk_w[pos[5:2]] = {b, 24'h000000};
        else
            blk_w[pos[5:2]] = blk_w[pos[5:2]] | (32'(b) << sh);
    endtask

    // Full 64-round compression of blk_w into chain_h.
    task automatic compress_block();
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
        for (int r = 0; r < 16; r++)
            w[r] = blk_w[r];
        for (int r = 16; r < 64; r++)
            w[r] = (rotr(w[r-2], 17) ^ rotr(w[r-2], 19) ^ (w[r-2] >> 10)) + w[r-7]
                 + (rotr(w[r-15], 7) ^ rotr(w[r-15], 18) ^ (w[r-15] >> 3)) + w[r-16];
        a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3];
        e = chain_h[4]; f = chain_h[5]; g = chain_h[6]; h = chain_h[7];
        for (int r = 0; r < 64; r++)
        begin
            t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
               + ROUND_K[r] + w[r];
            t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d;
        chain_h[4] += e; chain_h[5] += f; chain_h[6] += g; chain_h[7] += h;
    endtask

    // Advance the hash by one accepted request; on a close, queue the digest.
    task automatic absorb_request(input hash_req_t req);
        logic [5:0]    pos;
        logic [63:0]   bit_len;
        digest_entry_t ent;
        if (req.valid)
        begin
            pack_byte(msg_bytes[5:0], req.data);
            msg_bytes = msg_bytes + 61'd1;
            if (msg_bytes[5:0] == 6'd0)
                compress_block();
        end
        if (req.last)
        begin
            pos = msg_bytes[5:0];
            pack_byte(pos, MARK_BYTE);
            for (int j = int'(pos[5:2]) + 1; j < 16; j++)
                blk_w[j] = '0;
            // No room left for the length field: close this block, pad a new one.
            if (pos >= LEN_SLOT)
            begin
                compress_block();
                for (int j = 0; j < 16; j++)
                    blk_w[j] = '0;
            end
            bit_len = {msg_bytes, 3'b000};
            blk_w[14] = bit_len[63:32];
            blk_w[15] = bit_len[31:0];
            compress_block();
            for (int j = 0; j < 8; j++)
            begin
                ent.word  = chain_h[j];
                ent.index = 3'(j);
                ent.last  = (j == 7);
                digest_q.push_back(ent);
            end
            restart_message();
        end
    endtask

    task automatic add_req(input logic [7:0] data, input logic valid, input logic last);
        hash_req_t req;
        req.data  = data;
        req.valid = valid;
        req.last  = last;
        req_q.push_back(req);
    endtask

    // Request driver: present the next queued request, hold it until taken,
    // and drop valid for random bursts until the tail of the run.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            data_byte  <= 8'h00;
            byte_valid <= 1'b0;
            last_byte  <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                absorb_request(cur_req);
            // Port is free to change only when nothing is held or the held request just went.
            if (!in_valid || in_ready)
            begin
                calm = (req_q.size() <= CALM_TAIL);
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (req_q.size() == 0)
                    in_valid <= 1'b0;
                else if (!calm && $urandom_range(0, 9) == 0)
                begin
                    send_gap = $urandom_range(0, 11);
                    in_valid <= 1'b0;
                end
                else
                begin
                    cur_req = req_q.pop_front();
                    in_valid   <= 1'b1;
                    data_byte  <= cur_req.data;
                    byte_valid <= cur_req.valid;
                    last_byte  <= cur_req.last;
                end
            end
        end
    end

    // Digest monitor: compare each taken word with the oldest prediction and
    // stall the output in random bursts until the tail of the run.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (digest_q.size() == 0)
                begin
                    $display("%0t: unexpected digest word: expected none, got %h idx %0d last %0b",
                             $realtime, digest_word, word_index, last_word);
                    fails++;
                end
                else
                begin
                    if (digest_word !== digest_q[0].word)
                    begin
                        $display("%0t: digest_word expected %h got %h",
                                 $realtime, digest_q[0].word, digest_word);
                        fails++;
                    end
                    if (word_index !== digest_q[0].index)
                    begin
                        $display("%0t: word_index expected %0d got %0d",
                                 $realtime, digest_q[0].index, word_index);
                        fails++;
                    end
                    if (last_word !== digest_q[0].last)
                    begin
                        $display("%0t: last_word expected %0b got %0b",
                                 $realtime, digest_q[0].last, last_word);
                        fails++;
                    end
                    void'(digest_q.pop_front());
                end
            end
            if (hold_gap > 0)
            begin
                hold_gap--;
                out_ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                hold_gap = $urandom_range(0, 11);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin
        int len;
        int rand_reqs;
        bit close_on_byte;

        restart_message();

        // Directed: empty message, single extreme bytes, idle slots, a short
        // text, and a close without a byte after message bytes.
        add_req(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        add_req(8'h00, 1'b1, 1'b1);
        add_req(8'hff, 1'b1, 1'b1);
        add_req(8'ha5, 1'b0, 1'b0);
        add_req(8'h61, 1'b1, 1'b0);
        add_req(8'h62, 1'b1, 1'b0);
        add_req(8'h63, 1'b1, 1'b1);
        add_req(8'hff, 1'b1, 1'b0);
        add_req(8'h00, 1'b0, 1'b1);
        add_req(8'h5a, 1'b0, 1'b0);
        add_req(8'h55, 1'b1, 1'b0);
        add_req(8'hff, 1'b0, 1'b0);
        add_req(8'haa, 1'b1, 1'b1);

        // Random messages: mostly short, some on the padding and block
        // boundaries, some empty; idle slots sprinkled in as noise.
        rand_reqs = 0;
        while (rand_reqs < RAND_REQS)
        begin
            case ($urandom_range(0, 7))
                0:       len = BLOCK_EDGE_LENS[$urandom_range(0, 5)];
                1:       len = 0;
                default: len = $urandom_range(1, 20);
            endcase
            close_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                    add_req(8'($urandom_range(0, 255)), 1'b0, 1'b0);
                add_req(8'($urandom_range(0, 255)), 1'b1, close_on_byte && (i == len - 1));
                rand_reqs++;
            end
            if (!close_on_byte)
            begin
                add_req(8'($urandom_range(0, 255)), 1'b0, 1'b1);
                rand_reqs++;
            end
        end

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Drain: every request taken and every predicted word seen.
        while (req_q.size() != 0 || in_valid || digest_q.size() != 0)
            @(posedge clk);
        // Catch any stray words the block might still emit.
        repeat (DRAIN_WAIT) @(posedge clk);

        if (digest_q.size() != 0)
        begin
            $display("%0t: digest words missing: expected %0d more (next %h), got none",
                     $realtime, digest_q.size(), digest_q[0].word);
            fails++;
        end

        if (fails == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
